// ----- rtl/ecu_pkg.sv -----
// Shared types, opcode and function codes for the RV32I execute core.
package ecu_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam logic [31:0] PC_STEP = 32'd4;

  // Major opcodes
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // ALU funct3
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // Branch funct3
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // Load / store funct3
  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_ORDER   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_STORE = 2'd2
  } req_e;

  typedef enum logic [3:0] {
    K_LUI, K_AUIPC, K_JAL, K_JALR, K_BRANCH, K_LOAD, K_STORE, K_OPIMM, K_OP, K_BAD
  } kind_e;

  // Classified item handed from front to back
  typedef struct packed {
    logic        reply;
    logic        illegal;
    kind_e       kind;
    logic [2:0]  f3;
    logic        alt;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [4:0]  rd;
    logic [31:0] imm;
    logic [31:0] ldata;
  } dec_t;

  // Result item
  typedef struct packed {
    status_e     status;
    logic [31:0] next_pc;
    req_e        req;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [1:0]  size;
    logic        wb_en;
    logic [4:0]  wb_reg;
    logic [31:0] wb_value;
  } res_t;

  // Handshake between front queue and back
  typedef struct packed {
    logic valid;
    dec_t item;
  } head_t;

endpackage

// ----- rtl/ecu_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module ecu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ----- rtl/ecu_front.sv -----
// Front end: accepts items, decodes and classifies them, queues them for the back end.
module ecu_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  logic           func_i,
  input  logic [31:0]    instr_i,
  input  logic [31:0]    load_data_i,
  input  logic           deq_i,
  output ecu_pkg::head_t head_o
);

  ecu_pkg::dec_t dec;
  logic [6:0]    opc;
  logic [6:0]    f7;
  logic [2:0]    f3;
  logic          enq;

  ecu_pkg::dec_t ent_q [ecu_pkg::QDEPTH];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q;

  assign opc = instr_i[6:0];
  assign f3  = instr_i[14:12];
  assign f7  = instr_i[31:25];

  // Decode: class, legality and immediate format
  always_comb begin
    dec         = '0;
    dec.reply   = func_i;
    dec.f3      = f3;
    dec.rs1     = instr_i[19:15];
    dec.rs2     = instr_i[24:20];
    dec.rd      = instr_i[11:7];
    dec.ldata   = load_data_i;
    dec.imm     = {{20{instr_i[31]}}, instr_i[31:20]};
    dec.kind    = ecu_pkg::K_BAD;
    dec.illegal = 1'b0;
    case (opc)
      ecu_pkg::OPC_LUI: begin
        dec.kind = ecu_pkg::K_LUI;
        dec.imm  = {instr_i[31:12], 12'b0};
      end
      ecu_pkg::OPC_AUIPC: begin
        dec.kind = ecu_pkg::K_AUIPC;
        dec.imm  = {instr_i[31:12], 12'b0};
      end
      ecu_pkg::OPC_JAL: begin
        dec.kind = ecu_pkg::K_JAL;
        dec.imm  = {{12{instr_i[31]}}, instr_i[19:12], instr_i[20], instr_i[30:21], 1'b0};
      end
      ecu_pkg::OPC_JALR: begin
        dec.kind    = ecu_pkg::K_JALR;
        dec.illegal = (f3 != ecu_pkg::F3_ADD);
      end
      ecu_pkg::OPC_BRANCH: begin
        dec.kind    = ecu_pkg::K_BRANCH;
        dec.imm     = {{20{instr_i[31]}}, instr_i[7], instr_i[30:25], instr_i[11:8], 1'b0};
        dec.illegal = (f3 inside {ecu_pkg::F3_SLT, ecu_pkg::F3_SLTU});
      end
      ecu_pkg::OPC_LOAD: begin
        dec.kind    = ecu_pkg::K_LOAD;
        dec.illegal = !(f3 inside {ecu_pkg::F3_LB, ecu_pkg::F3_LH, ecu_pkg::F3_LW,
                                   ecu_pkg::F3_LBU, ecu_pkg::F3_LHU});
      end
      ecu_pkg::OPC_STORE: begin
        dec.kind    = ecu_pkg::K_STORE;
        dec.imm     = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
        dec.illegal = !(f3 inside {ecu_pkg::F3_LB, ecu_pkg::F3_LH, ecu_pkg::F3_LW});
      end
      ecu_pkg::OPC_OPIMM: begin
        dec.kind = ecu_pkg::K_OPIMM;
        if (f3 == ecu_pkg::F3_SLL) begin
          dec.illegal = (f7 != ecu_pkg::F7_BASE);
        end else if (f3 == ecu_pkg::F3_SR) begin
          dec.illegal = !(f7 inside {ecu_pkg::F7_BASE, ecu_pkg::F7_ALT});
          dec.alt     = (f7 == ecu_pkg::F7_ALT);
        end
      end
      ecu_pkg::OPC_OP: begin
        dec.kind = ecu_pkg::K_OP;
        dec.alt  = (f7 == ecu_pkg::F7_ALT);
        if (f7 == ecu_pkg::F7_ALT) begin
          dec.illegal = !(f3 inside {ecu_pkg::F3_ADD, ecu_pkg::F3_SR});
        end else begin
          dec.illegal = (f7 != ecu_pkg::F7_BASE);
        end
      end
      default: begin
        dec.illegal = 1'b1;
      end
    endcase
  end

  // Two-entry queue to the back end
  assign full_o = (cnt_q == 2'(ecu_pkg::QDEPTH));
  assign enq    = push_i && !full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (enq) begin
        wptr_q <= ~wptr_q;
      end
      if (deq_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      ent_q[wptr_q] <= dec;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = ent_q[rptr_q];

endmodule

// ----- rtl/ecu_back.sv -----
// Back end: register file read, execute, architectural state and result queue.
module ecu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ecu_pkg::head_t head_i,
  output logic           deq_o,
  input  logic           pop_i,
  output logic           empty_o,
  output ecu_pkg::res_t  res_o
);

  logic          ex_v_q;
  ecu_pkg::dec_t ex_q;
  logic          ex_fire;
  logic          issue;

  logic [31:0]   pc_q;
  logic          pend_q;
  logic [4:0]    ldest_q;
  logic [2:0]    lkind_q;
  logic [31:0]   vld_q;
  logic          vld_a_q, vld_b_q;
  logic          lw_en_q;
  logic [4:0]    lw_reg_q;
  logic [31:0]   lw_val_q;

  logic [31:0]   rdata_a, rdata_b;
  logic [31:0]   opa, opb, alu_b, alu_res;
  logic [31:0]   sum_ai, pc_imm, pc_next;
  logic          taken;
  logic          wr;
  logic [4:0]    rd;
  logic [31:0]   wval;
  logic          rf_we;
  ecu_pkg::res_t res;

  ecu_pkg::res_t ent_q [ecu_pkg::QDEPTH];
  logic          wptr_q, rptr_q;
  logic [1:0]    ocnt_q;
  logic          opop;

  // Issue from the front queue when execute can move on
  assign ex_fire = ex_v_q && (ocnt_q != 2'(ecu_pkg::QDEPTH));
  assign issue   = head_i.valid && (!ex_v_q || ex_fire);
  assign deq_o   = issue;

  ecu_ram #(
    .Width(32),
    .Depth(32)
  ) u_rf (
    .clk_i    (clk_i),
    .we_i     (rf_we),
    .waddr_i  (rd),
    .wdata_i  (wval),
    .re_i     (issue),
    .raddr_a_i(head_i.item.rs1),
    .raddr_b_i(head_i.item.rs2),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  // Execute stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_v_q  <= 1'b0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (issue) begin
        ex_v_q  <= 1'b1;
        vld_a_q <= vld_q[head_i.item.rs1];
        vld_b_q <= vld_q[head_i.item.rs2];
      end else if (ex_fire) begin
        ex_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      ex_q <= head_i.item;
    end
  end

  // Operands: bypass the latest write, unwritten registers read as zero
  assign opa = (lw_en_q && lw_reg_q == ex_q.rs1) ? lw_val_q : (vld_a_q ? rdata_a : '0);
  assign opb = (lw_en_q && lw_reg_q == ex_q.rs2) ? lw_val_q : (vld_b_q ? rdata_b : '0);

  assign sum_ai  = opa + ex_q.imm;
  assign pc_imm  = pc_q + ex_q.imm;
  assign pc_next = pc_q + ecu_pkg::PC_STEP;
  assign alu_b   = (ex_q.kind == ecu_pkg::K_OP) ? opb : ex_q.imm;

  // ALU shared by OP and OP-IMM
  always_comb begin
    case (ex_q.f3)
      ecu_pkg::F3_ADD:  alu_res = ex_q.alt ? opa - alu_b : opa + alu_b;
      ecu_pkg::F3_SLL:  alu_res = opa << alu_b[4:0];
      ecu_pkg::F3_SLT:  alu_res = {31'b0, $signed(opa) < $signed(alu_b)};
      ecu_pkg::F3_SLTU: alu_res = {31'b0, opa < alu_b};
      ecu_pkg::F3_XOR:  alu_res = opa ^ alu_b;
      ecu_pkg::F3_SR:   alu_res = ex_q.alt ? 32'($signed(opa) >>> alu_b[4:0])
                                           : opa >> alu_b[4:0];
      ecu_pkg::F3_OR:   alu_res = opa | alu_b;
      default:          alu_res = opa & alu_b;
    endcase
  end

  // Branch condition
  always_comb begin
    case (ex_q.f3)
      ecu_pkg::F3_BEQ:  taken = (opa == opb);
      ecu_pkg::F3_BNE:  taken = (opa != opb);
      ecu_pkg::F3_BLT:  taken = $signed(opa) < $signed(opb);
      ecu_pkg::F3_BGE:  taken = !($signed(opa) < $signed(opb));
      ecu_pkg::F3_BLTU: taken = (opa < opb);
      default:          taken = (opa >= opb);
    endcase
  end

  // Result of the item in execute
  always_comb begin
    res         = '0;
    res.status  = ecu_pkg::ST_OK;
    res.req     = ecu_pkg::REQ_NONE;
    res.next_pc = pc_q;
    wr          = 1'b0;
    rd          = ex_q.rd;
    wval        = '0;
    if (ex_q.reply) begin
      if (!pend_q) begin
        res.status = ecu_pkg::ST_ORDER;
      end else begin
        rd = ldest_q;
        wr = 1'b1;
        case (lkind_q)
          ecu_pkg::F3_LB:  wval = {{24{ex_q.ldata[7]}}, ex_q.ldata[7:0]};
          ecu_pkg::F3_LH:  wval = {{16{ex_q.ldata[15]}}, ex_q.ldata[15:0]};
          ecu_pkg::F3_LBU: wval = {24'b0, ex_q.ldata[7:0]};
          ecu_pkg::F3_LHU: wval = {16'b0, ex_q.ldata[15:0]};
          default:         wval = ex_q.ldata;
        endcase
      end
    end else if (pend_q) begin
      res.status = ecu_pkg::ST_ORDER;
    end else if (ex_q.illegal) begin
      res.status = ecu_pkg::ST_ILLEGAL;
    end else begin
      res.next_pc = pc_next;
      case (ex_q.kind)
        ecu_pkg::K_LUI: begin
          wr = 1'b1; wval = ex_q.imm;
        end
        ecu_pkg::K_AUIPC: begin
          wr = 1'b1; wval = pc_imm;
        end
        ecu_pkg::K_JAL: begin
          wr = 1'b1; wval = pc_next; res.next_pc = pc_imm;
        end
        ecu_pkg::K_JALR: begin
          wr = 1'b1; wval = pc_next; res.next_pc = {sum_ai[31:1], 1'b0};
        end
        ecu_pkg::K_BRANCH: begin
          if (taken) begin
            res.next_pc = pc_imm;
          end
        end
        ecu_pkg::K_LOAD: begin
          res.req  = ecu_pkg::REQ_LOAD;
          res.addr = sum_ai;
          res.size = ex_q.f3[1:0];
        end
        ecu_pkg::K_STORE: begin
          res.req   = ecu_pkg::REQ_STORE;
          res.addr  = sum_ai;
          res.wdata = opb;
          res.size  = ex_q.f3[1:0];
        end
        default: begin
          wr = 1'b1; wval = alu_res;
        end
      endcase
    end
    // x0 discards the result
    if (wr && rd != '0) begin
      res.wb_en    = 1'b1;
      res.wb_reg   = rd;
      res.wb_value = wval;
    end
  end

  assign rf_we = ex_fire && res.wb_en;

  // Architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      pend_q   <= 1'b0;
      ldest_q  <= '0;
      lkind_q  <= '0;
      vld_q    <= '0;
      lw_en_q  <= 1'b0;
      lw_reg_q <= '0;
      lw_val_q <= '0;
    end else if (ex_fire) begin
      pc_q <= res.next_pc;
      if (ex_q.reply && pend_q) begin
        pend_q <= 1'b0;
      end else if (res.req == ecu_pkg::REQ_LOAD) begin
        pend_q  <= 1'b1;
        ldest_q <= ex_q.rd;
        lkind_q <= ex_q.f3;
      end
      if (res.wb_en) begin
        vld_q[res.wb_reg] <= 1'b1;
        lw_en_q           <= 1'b1;
        lw_reg_q          <= res.wb_reg;
        lw_val_q          <= res.wb_value;
      end
    end
  end

  // Result queue
  assign opop    = pop_i && (ocnt_q != '0);
  assign empty_o = (ocnt_q == '0);
  assign res_o   = ent_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      ocnt_q <= '0;
    end else begin
      if (ex_fire) begin
        wptr_q <= ~wptr_q;
      end
      if (opop) begin
        rptr_q <= ~rptr_q;
      end
      ocnt_q <= ocnt_q + {1'b0, ex_fire} - {1'b0, opop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire) begin
      ent_q[wptr_q] <= res;
    end
  end

endmodule

// ----- rtl/rv32i_execute_core_unit.sv -----
// RV32I execute core: one instruction or load reply per item, one result each.
// Throughput: one item per cycle while the result queue has room, set by the
// single execute stage and the register file's registered read with bypass of
// the latest write.
// Reset: pc, pending load and all register-file valid bits cleared at once;
// unwritten registers read as zero, so the block is ready right after reset.
module rv32i_execute_core_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        func_i,
  input  logic [31:0] instr_i,
  input  logic [31:0] load_data_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [31:0] next_pc_o,
  output logic [1:0]  mem_req_o,
  output logic [31:0] mem_addr_o,
  output logic [31:0] mem_wdata_o,
  output logic [1:0]  mem_size_o,
  output logic        wb_en_o,
  output logic [4:0]  wb_reg_o,
  output logic [31:0] wb_value_o
);

  ecu_pkg::head_t head;
  logic           deq;
  ecu_pkg::res_t  res;

  ecu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .func_i     (func_i),
    .instr_i    (instr_i),
    .load_data_i(load_data_i),
    .deq_i      (deq),
    .head_o     (head)
  );

  ecu_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .deq_o  (deq),
    .pop_i  (pop),
    .empty_o(empty),
    .res_o  (res)
  );

  assign status_o    = res.status;
  assign next_pc_o   = res.next_pc;
  assign mem_req_o   = res.req;
  assign mem_addr_o  = res.addr;
  assign mem_wdata_o = res.wdata;
  assign mem_size_o  = res.size;
  assign wb_en_o     = res.wb_en;
  assign wb_reg_o    = res.wb_reg;
  assign wb_value_o  = res.wb_value;

`ifndef SYNTHESIS
  // No write-back fields without a write
  a_wb_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !wb_en_o |-> wb_reg_o == 5'd0 && wb_value_o == 32'd0)
    else $error("write-back fields set without write");

  // A rejected item leaves no request and no write
  a_reject_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && status_o != ecu_pkg::ST_OK |-> mem_req_o == ecu_pkg::REQ_NONE && !wb_en_o)
    else $error("rejected item has side effects");

  // Memory request and register write never come together
  a_req_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && mem_req_o != ecu_pkg::REQ_NONE |-> !wb_en_o)
    else $error("memory request with write-back");
`endif

endmodule

// ----- sim/ecu_checker.sv -----
// Checker for the RV32I execute core: predicts each result item and compares it.
`timescale 1ns / 1ps

module ecu_checker
  import ecu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic        func_i,
  input  logic [31:0] instr_i,
  input  logic [31:0] load_data_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] next_pc_i,
  input  logic [1:0]  mem_req_i,
  input  logic [31:0] mem_addr_i,
  input  logic [31:0] mem_wdata_i,
  input  logic [1:0]  mem_size_i,
  input  logic        wb_en_i,
  input  logic [4:0]  wb_reg_i,
  input  logic [31:0] wb_value_i,
  output int          errors_o,
  output int          waiting_o
);

  // Architectural state shadow
  logic [31:0] regs [32];
  logic [31:0] pc;
  logic        ld_busy;
  logic [4:0]  ld_rd;
  logic [2:0]  ld_f3;
  res_t        expected_q[$];

  assign waiting_o = expected_q.size();

  function automatic logic [31:0] alu_calc(logic [2:0] f3, logic alt, logic [31:0] a,
                                           logic [31:0] b);
    case (f3)
      F3_ADD:  return alt ? a - b : a + b;
      F3_SLL:  return a << b[4:0];
      F3_SLT:  return {31'd0, $signed(a) < $signed(b)};
      F3_SLTU: return {31'd0, a < b};
      F3_XOR:  return a ^ b;
      F3_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      F3_OR:   return a | b;
      default: return a & b;
    endcase
  endfunction

  // Executes one item against the shadow state
  function automatic res_t execute_item(logic fn, logic [31:0] w, logic [31:0] ld);
    res_t r;
    logic ok, wr, taken;
    logic [31:0] a, b, immi, nxt, wv;
    logic [4:0] rd;
    logic [2:0] f3;
    logic [6:0] f7;
    r = '0;
    r.status = ST_OK;
    r.req = REQ_NONE;
    r.next_pc = pc;
    wr = 1'b0;
    wv = '0;
    rd = '0;
    if (fn) begin
      if (!ld_busy) r.status = ST_ORDER;
      else begin
        case (ld_f3)
          F3_LB:   wv = {{24{ld[7]}}, ld[7:0]};
          F3_LH:   wv = {{16{ld[15]}}, ld[15:0]};
          F3_LBU:  wv = {24'd0, ld[7:0]};
          F3_LHU:  wv = {16'd0, ld[15:0]};
          default: wv = ld;
        endcase
        rd = ld_rd;
        wr = 1'b1;
        ld_busy = 1'b0;
      end
    end else if (ld_busy) begin
      r.status = ST_ORDER;
    end else begin
      f3 = w[14:12];
      f7 = w[31:25];
      a = regs[w[19:15]];
      b = regs[w[24:20]];
      immi = {{20{w[31]}}, w[31:20]};
      nxt = pc + PC_STEP;
      rd = w[11:7];
      ok = 1'b1;
      case (w[6:0])
        OPC_LUI: begin wv = {w[31:12], 12'd0}; wr = 1'b1; r.next_pc = nxt; end
        OPC_AUIPC: begin wv = pc + {w[31:12], 12'd0}; wr = 1'b1; r.next_pc = nxt; end
        OPC_JAL: begin
          wv = nxt; wr = 1'b1;
          r.next_pc = pc + {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
        end
        OPC_JALR: begin
          if (f3 != 3'd0) ok = 1'b0;
          else begin wv = nxt; wr = 1'b1; r.next_pc = (a + immi) & ~32'd1; end
        end
        OPC_BRANCH: begin
          case (f3)
            F3_BEQ:  taken = a == b;
            F3_BNE:  taken = a != b;
            F3_BLT:  taken = $signed(a) < $signed(b);
            F3_BGE:  taken = $signed(a) >= $signed(b);
            F3_BLTU: taken = a < b;
            F3_BGEU: taken = a >= b;
            default: begin taken = 1'b0; ok = 1'b0; end
          endcase
          r.next_pc = taken ? pc + {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0} : nxt;
        end
        OPC_LOAD: begin
          if (!(f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU})) ok = 1'b0;
          else begin
            r.req = REQ_LOAD; r.addr = a + immi; r.size = f3[1:0];
            ld_busy = 1'b1; ld_rd = rd; ld_f3 = f3; r.next_pc = nxt;
          end
        end
        OPC_STORE: begin
          if (f3 > 3'd2) ok = 1'b0;
          else begin
            r.req = REQ_STORE; r.addr = a + {{20{w[31]}}, w[31:25], w[11:7]};
            r.wdata = b; r.size = f3[1:0]; r.next_pc = nxt;
          end
        end
        OPC_OPIMM: begin
          if (f3 == F3_SLL) begin
            ok = f7 == F7_BASE;
            wv = alu_calc(f3, 1'b0, a, {27'd0, w[24:20]});
          end else if (f3 == F3_SR) begin
            ok = f7 == F7_BASE || f7 == F7_ALT;
            wv = alu_calc(f3, f7 == F7_ALT, a, {27'd0, w[24:20]});
          end else wv = alu_calc(f3, 1'b0, a, immi);
          wr = 1'b1; r.next_pc = nxt;
        end
        OPC_OP: begin
          if (f7 == F7_ALT) ok = f3 == F3_ADD || f3 == F3_SR;
          else if (f7 != F7_BASE) ok = 1'b0;
          wv = alu_calc(f3, f7 == F7_ALT, a, b);
          wr = 1'b1; r.next_pc = nxt;
        end
        default: ok = 1'b0;
      endcase
      if (!ok) begin
        r = '0;
        r.status = ST_ILLEGAL;
        r.req = REQ_NONE;
        r.next_pc = pc;
        wr = 1'b0;
      end
      pc = r.next_pc;
    end
    // x0 writes are dropped
    if (wr && rd != 5'd0) begin
      regs[rd] = wv;
      r.wb_en = 1'b1; r.wb_reg = rd; r.wb_value = wv;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      errors_o++;
    end
  endtask

  // Predict on input handshakes, compare on result handshakes
  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      foreach (regs[i]) regs[i] = '0;
      pc = '0;
      ld_busy = 1'b0;
      ld_rd = '0;
      ld_f3 = '0;
      expected_q.delete();
      errors_o = 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result item, status %0d pc %h", $time, status_i,
                   next_pc_i);
          errors_o++;
        end else begin
          e = expected_q.pop_front();
          check_field("status", e.status, status_i);
          check_field("next_pc", e.next_pc, next_pc_i);
          check_field("mem_req", e.req, mem_req_i);
          check_field("mem_addr", e.addr, mem_addr_i);
          check_field("mem_wdata", e.wdata, mem_wdata_i);
          check_field("mem_size", e.size, mem_size_i);
          check_field("wb_en", e.wb_en, wb_en_i);
          check_field("wb_reg", e.wb_reg, wb_reg_i);
          check_field("wb_value", e.wb_value, wb_value_i);
        end
      end
      if (push_i && !full_i) expected_q.push_back(execute_item(func_i, instr_i, load_data_i));
    end
  end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the RV32I execute core: stimulus, clock, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
  import ecu_pkg::*;

  localparam int RandItems = 1600;
  localparam int StallLimit = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        func_i = 1'b0;
  logic [31:0] instr_i = '0;
  logic [31:0] load_data_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  status_o, mem_req_o, mem_size_o;
  logic [31:0] next_pc_o, mem_addr_o, mem_wdata_o, wb_value_o;
  logic        wb_en_o;
  logic [4:0]  wb_reg_o;
  int          errors, waiting, quiet;
  logic        busy_idle = 1'b1;
  logic        load_open = 1'b0;

  always #5 clk_i = ~clk_i;

  rv32i_execute_core_unit DUT (.*);

  ecu_checker u_checker (
    .clk_i, .rst_ni, .push_i(push), .full_i(full), .func_i, .instr_i, .load_data_i,
    .empty_i(empty), .pop_i(pop), .status_i(status_o), .next_pc_i(next_pc_o),
    .mem_req_i(mem_req_o), .mem_addr_i(mem_addr_o), .mem_wdata_i(mem_wdata_o),
    .mem_size_i(mem_size_o), .wb_en_i(wb_en_o), .wb_reg_i(wb_reg_o),
    .wb_value_i(wb_value_o), .errors_o(errors), .waiting_o(waiting)
  );

  // Encoders for the instruction formats
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  // Random well-formed instruction, with some raw noise words
  function automatic logic [31:0] random_instr();
    int k;
    logic [2:0] f3;
    logic [6:0] f7;
    k = $urandom_range(0, 99);
    f3 = 3'($urandom);
    if (k < 8) return {20'($urandom), 5'($urandom), OPC_LUI};
    if (k < 12) return {20'($urandom), 5'($urandom), OPC_AUIPC};
    if (k < 17) return enc_j(21'($urandom_range(0, 255)) << 1 ^ ({21{$urandom_range(0, 1) == 1}}
                             & 21'h1ffe00), 5'($urandom));
    if (k < 21) return enc_i(12'($urandom), 5'($urandom), 3'd0, 5'($urandom), OPC_JALR);
    if (k < 31) begin
      if (f3 inside {3'd2, 3'd3}) f3 = F3_BEQ;
      return enc_b(13'($urandom), 5'($urandom), 5'($urandom), f3);
    end
    if (k < 43) begin
      if (f3 inside {3'd3, 3'd6, 3'd7}) f3 = F3_LW;
      return enc_i(12'($urandom), 5'($urandom), f3, 5'($urandom), OPC_LOAD);
    end
    if (k < 53) return enc_s(12'($urandom), 5'($urandom), 5'($urandom), 3'($urandom_range(0, 2)));
    if (k < 73) begin
      if (f3 == F3_SLL || f3 == F3_SR)
        return enc_r(($urandom_range(0, 1) == 1 && f3 == F3_SR) ? F7_ALT : F7_BASE,
                     5'($urandom), 5'($urandom), f3, 5'($urandom), OPC_OPIMM);
      return enc_i(12'($urandom), 5'($urandom), f3, 5'($urandom), OPC_OPIMM);
    end
    if (k < 90) begin
      f7 = ($urandom_range(0, 1) == 1 && (f3 == F3_ADD || f3 == F3_SR)) ? F7_ALT : F7_BASE;
      return enc_r(f7, 5'($urandom), 5'($urandom), f3, 5'($urandom), OPC_OP);
    end
    return $urandom;
  endfunction

  // Offers one item and holds it until the core takes it
  task automatic send(logic fn, logic [31:0] w, logic [31:0] ld);
    while (busy_idle && $urandom_range(0, 99) < 23) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    func_i <= fn;
    instr_i <= w;
    load_data_i <= ld;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    // track the pending load as the core should see it
    if (fn) load_open = 1'b0;
    else if (!load_open && w[6:0] == OPC_LOAD && w[14:12] inside {F3_LB, F3_LH, F3_LW,
             F3_LBU, F3_LHU}) load_open = 1'b1;
  endtask

  // Result side stalls at random
  always @(posedge clk_i) pop <= !busy_idle || $urandom_range(0, 99) >= 23;

  // Watchdog on handshake progress
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] w;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every class, each corner case
    send(1'b1, '0, 32'hffff_ffff);                                // reply with no load
    send(1'b0, {20'hfffff, 5'd1, OPC_LUI}, '0);                    // x1 = 0xfffff000
    send(1'b0, enc_i(12'hfff, 5'd1, F3_ADD, 5'd2, OPC_OPIMM), '0); // x2 = x1 - 1
    send(1'b0, enc_i(12'h7ff, 5'd0, F3_ADD, 5'd3, OPC_OPIMM), '0);
    send(1'b0, enc_r(F7_ALT, 5'd2, 5'd3, F3_ADD, 5'd4, OPC_OP), '0);  // sub
    send(1'b0, enc_r(F7_BASE, 5'd3, 5'd2, F3_SLT, 5'd5, OPC_OP), '0);
    send(1'b0, enc_r(F7_BASE, 5'd3, 5'd2, F3_SLTU, 5'd6, OPC_OP), '0);
    send(1'b0, enc_r(F7_ALT, 5'd31, 5'd1, F3_SR, 5'd7, OPC_OPIMM), '0); // srai by 31
    send(1'b0, enc_r(F7_ALT, 5'd3, 5'd1, F3_SR, 5'd8, OPC_OP), '0);     // sra
    send(1'b0, {20'h80000, 5'd0, OPC_LUI}, '0);                          // x0 dest
    for (int f = 0; f < 8; f++) begin
      if (f == 3 || f > 5) continue;
      send(1'b0, enc_i(12'h801, 5'd2, 3'(f), 5'(9 + f), OPC_LOAD), '0);
      if (f == 0) send(1'b0, {20'h1, 5'd1, OPC_LUI}, '0);           // ignored while waiting
      send(1'b1, '0, 32'h8000_8080);
    end
    send(1'b0, enc_i(12'h0, 5'd0, F3_LW, 5'd0, OPC_LOAD), '0);     // load to x0
    send(1'b1, '0, 32'h1234_5678);
    for (int f = 0; f < 3; f++) send(1'b0, enc_s(12'h800, 5'd2, 5'd1, 3'(f)), '0);
    send(1'b0, enc_b(13'h1ffc, 5'd3, 5'd2, F3_BLT), '0);
    send(1'b0, enc_b(13'h0ffe, 5'd3, 5'd2, F3_BLTU), '0);
    send(1'b0, enc_j(21'h1ffffc, 5'd1), '0);
    send(1'b0, enc_i(12'h7ff, 5'd2, 3'd0, 5'd10, OPC_JALR), '0);  // even target
    send(1'b0, 32'h0ff0_000f, '0);                                  // fence
    send(1'b0, 32'h0000_0073, '0);                                  // ecall
    send(1'b0, enc_b(13'h8, 5'd0, 5'd0, 3'd2), '0);                 // bad branch funct3

    // Random: mostly well-formed load/reply pairs among other instructions
    for (int n = 0; n < RandItems; n++) begin
      busy_idle <= !(n >= 700 && n < 1000);
      if (n == 300) begin
        push <= 1'b0;
        while (waiting != 0) @(posedge clk_i);
      end
      if (load_open && $urandom_range(0, 99) < 90) send(1'b1, '0, $urandom);
      else if (!load_open && $urandom_range(0, 99) < 3) send(1'b1, '0, $urandom);
      else begin
        w = random_instr();
        send(1'b0, w, $urandom);
      end
    end
    push <= 1'b0;
    busy_idle <= 1'b1;

    while (waiting != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
